// File: sv/ckfc_pkg.sv
// Shared types, constants and helpers for the chroma key flood classifier.
// No dependencies; every other file imports this package.
`default_nettype none

package ckfc_pkg;

  localparam int CHAN_W     = 8;
  localparam int TOL_W      = 16;
  localparam int FRAC_W     = 8;
  localparam int BUDGET_W   = 4;
  localparam int COUNT_W    = 3;
  localparam int GRANT_W    = 3;
  localparam int KEY_WORD_W = 42;
  localparam int CFG_IDX_W  = 3;

  // Grant codes beyond the key indexes
  localparam logic [GRANT_W-1:0] GRANT_CLEAR   = 3'd4;
  localparam logic [GRANT_W-1:0] GRANT_REFUSED = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0    = 3'd0,
    REG_KEY1    = 3'd1,
    REG_KEY2    = 3'd2,
    REG_KEY3    = 3'd3,
    REG_KEY_CNT = 3'd4,
    REG_BUDGET  = 3'd5,
    REG_MARGIN  = 3'd6
  } cfg_idx_t;

  // Key word layout, LSB first: red, green, blue, tolerance, island, spare
  typedef struct packed {
    logic              spare;
    logic              island;
    logic [TOL_W-1:0]  tol;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } key_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  keys_in_use;
    logic [BUDGET_W-1:0] budget;
    logic [TOL_W-1:0]    margin;
  } settings_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [CHAN_W-1:0]   alpha;
    logic [GRANT_W-1:0]  from;
    logic [BUDGET_W-1:0] spent;
  } pixel_t;

  function automatic logic [CHAN_W-1:0] chan_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Largest per-channel distance, whole channel steps
  function automatic logic [CHAN_W-1:0] max_chan_gap(input key_t key, input pixel_t pix);
    logic [CHAN_W-1:0] d;
    logic [CHAN_W-1:0] e;
    logic [CHAN_W-1:0] f;
    d = chan_diff(pix.red, key.red);
    e = chan_diff(pix.green, key.green);
    f = chan_diff(pix.blue, key.blue);
    if (e > d) d = e;
    if (f > d) d = f;
    return d;
  endfunction

endpackage

`default_nettype wire

// File: sv/ckfc_pixel_if.sv
// Input channel: one flooded pixel with its arriving key and spent budget.
// Depends on ckfc_pkg.
`default_nettype none

interface ckfc_pixel_if;
  import ckfc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   pixel_red;
  logic [CHAN_W-1:0]   pixel_green;
  logic [CHAN_W-1:0]   pixel_blue;
  logic [CHAN_W-1:0]   pixel_alpha;
  logic [GRANT_W-1:0]  arriving_key;
  logic [BUDGET_W-1:0] spent_budget;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                  arriving_key, spent_budget, input ready);
  modport sink (input valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                arriving_key, spent_budget, output ready);
endinterface

`default_nettype wire

// File: sv/ckfc_grant_if.sv
// Output channel: granted key code and budget spent after the pixel.
// Depends on ckfc_pkg.
`default_nettype none

interface ckfc_grant_if;
  import ckfc_pkg::*;

  logic                valid;
  logic                ready;
  logic [GRANT_W-1:0]  granted_key;
  logic [BUDGET_W-1:0] budget_after;

  modport source (output valid, granted_key, budget_after, input ready);
  modport sink (input valid, granted_key, budget_after, output ready);
endinterface

`default_nettype wire

// File: sv/ckfc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on ckfc_pkg.
`default_nettype none

interface ckfc_cfg_if;
  import ckfc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [KEY_WORD_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/chroma_key_flood_classifier.sv
// Top level of the chroma key flood classifier.
// Depends on ckfc_pkg, the channel interfaces, ckfc_cfg and ckfc_core.
//
// Classifies one flooded pixel per clock: an item accepted on the pixel
// channel yields its result on the grant channel after passing one input
// register and one result register, and a new item is taken every cycle while
// the grant side keeps up. All key slots are matched in parallel between the
// two registers, so throughput is one item per cycle unless the grant side
// stalls. Ready on the pixel side follows the grant side combinationally
// through the two register stages. Configuration writes are always accepted and
// must only be issued while no item is in flight. No clearing pass after reset.
`default_nettype none

module chroma_key_flood_classifier #(
  parameter int KEY_SLOTS   = 4,
  parameter int BUDGET_BITS = 4
) (
  input  logic         clk,
  input  logic         rst,
  ckfc_pixel_if.sink   pixel,
  ckfc_grant_if.source grant,
  ckfc_cfg_if.sink     cfg
);
  import ckfc_pkg::*;

  key_t      keys [KEY_SLOTS];
  settings_t settings;

  ckfc_cfg #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .keys     (keys),
    .settings (settings)
  );

  ckfc_core #(
    .KEY_SLOTS   (KEY_SLOTS),
    .BUDGET_BITS (BUDGET_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pixel),
    .grant    (grant),
    .keys     (keys),
    .settings (settings)
  );

endmodule

`default_nettype wire

// File: sv/ckfc_cfg.sv
// Configuration register file: key slots, key count, crevice budget and margin.
// Depends on ckfc_pkg and ckfc_cfg_if.
`default_nettype none

module ckfc_cfg #(
  parameter int KEY_SLOTS = 4
) (
  input  logic             clk,
  input  logic             rst,
  ckfc_cfg_if.sink         cfg,
  output ckfc_pkg::key_t   keys [KEY_SLOTS],
  output ckfc_pkg::settings_t settings
);
  import ckfc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEY_SLOTS; k++) begin
        keys[k] <= '0;
      end
    end else if (cfg.valid) begin
      for (int k = 0; k < KEY_SLOTS; k++) begin
        if (cfg.index == CFG_IDX_W'(int'(REG_KEY0) + k)) begin
          keys[k] <= key_t'(cfg.data);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settings <= '0;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        REG_KEY_CNT: settings.keys_in_use <= cfg.data[COUNT_W-1:0];
        REG_BUDGET:  settings.budget      <= cfg.data[BUDGET_W-1:0];
        REG_MARGIN:  settings.margin      <= cfg.data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/ckfc_core.sv
// Classifier datapath: input register, key match and decision logic, result register.
// Depends on ckfc_pkg, ckfc_pixel_if and ckfc_grant_if.
`default_nettype none

module ckfc_core #(
  parameter int KEY_SLOTS   = 4,
  parameter int BUDGET_BITS = 4
) (
  input  logic                clk,
  input  logic                rst,
  ckfc_pixel_if.sink          pixel,
  ckfc_grant_if.source        grant,
  input  ckfc_pkg::key_t      keys [KEY_SLOTS],
  input  ckfc_pkg::settings_t settings
);
  import ckfc_pkg::*;

  localparam int EFF_BITS = (BUDGET_BITS < BUDGET_W) ? BUDGET_BITS : BUDGET_W;
  localparam logic [BUDGET_W-1:0] BUDGET_MASK = BUDGET_W'((1 << EFF_BITS) - 1);
  localparam logic [COUNT_W-1:0]  SLOT_COUNT  = COUNT_W'(KEY_SLOTS);

  // Stage 1: registered input item
  logic   s1_valid;
  pixel_t s1_pix;
  // Stage 2: result register
  logic                o_valid;
  logic [GRANT_W-1:0]  o_key;
  logic [BUDGET_W-1:0] o_budget;

  logic adv2;
  logic take1;

  logic [COUNT_W-1:0]  valid_n;
  logic [CHAN_W-1:0]   span [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] hit;
  logic [KEY_SLOTS-1:0] claim;
  logic [CHAN_W-1:0]   from_dist;
  logic [TOL_W-1:0]    from_tol;
  logic                from_hit;
  logic [GRANT_W-1:0]  claim_key;
  logic [BUDGET_W-1:0] spent;
  logic [BUDGET_W-1:0] reach;
  logic [TOL_W:0]      wide_tol;
  logic                crev_ok;
  logic [GRANT_W-1:0]  key_next;
  logic [BUDGET_W-1:0] budget_next;

  assign adv2        = !o_valid || grant.ready;
  assign take1       = !s1_valid || adv2;
  assign pixel.ready = take1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take1) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take1 && pixel.valid) begin
      s1_pix <= '{red: pixel.pixel_red, green: pixel.pixel_green,
                  blue: pixel.pixel_blue, alpha: pixel.pixel_alpha,
                  from: pixel.arriving_key, spent: pixel.spent_budget};
    end
  end

  // Key match: all slots in parallel
  always_comb begin
    valid_n = (settings.keys_in_use > SLOT_COUNT) ? SLOT_COUNT : settings.keys_in_use;
    from_dist = '0;
    from_tol  = '0;
    from_hit  = 1'b0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      span[k]  = max_chan_gap(keys[k], s1_pix);
      hit[k]   = {span[k], {FRAC_W{1'b0}}} <= keys[k].tol;
      claim[k] = hit[k] && !keys[k].island && (COUNT_W'(k) < valid_n);
      if (s1_pix.from == GRANT_W'(k)) begin
        from_dist = span[k];
        from_tol  = keys[k].tol;
        from_hit  = hit[k];
      end
    end
    claim_key = GRANT_REFUSED;
    for (int k = KEY_SLOTS - 1; k >= 0; k--) begin
      if (claim[k]) claim_key = GRANT_W'(k);
    end
  end

  // Decision
  always_comb begin
    spent    = s1_pix.spent & BUDGET_MASK;
    reach    = settings.budget & BUDGET_MASK;
    wide_tol = {1'b0, from_tol} + {1'b0, settings.margin};
    crev_ok  = (reach != '0) && (spent < reach) &&
               ({1'b0, from_dist, {FRAC_W{1'b0}}} <= wide_tol);
    key_next    = GRANT_REFUSED;
    budget_next = spent;
    if (s1_pix.alpha == '0) begin
      key_next = GRANT_CLEAR;
    end else if (s1_pix.from == GRANT_CLEAR) begin
      key_next = claim_key;
    end else if (s1_pix.from >= valid_n) begin
      key_next = GRANT_REFUSED;
    end else if (from_hit) begin
      key_next = s1_pix.from;
    end else if (|claim) begin
      key_next = claim_key;
    end else if (crev_ok) begin
      key_next    = s1_pix.from;
      budget_next = spent + BUDGET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv2) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      o_key    <= key_next;
      o_budget <= budget_next;
    end
  end

  assign grant.valid        = o_valid;
  assign grant.granted_key  = o_key;
  assign grant.budget_after = o_budget;

  // A result stalled downstream keeps the staged item in place
  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv2 |=> s1_valid && $stable(s1_pix))
    else $error("staged item lost while result stalled");

  // Transparent pixels always come out clear
  a_clear: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv2 && (s1_pix.alpha == '0) |=> o_key == GRANT_CLEAR)
    else $error("transparent pixel not granted clear");

  // Budget only moves on a crevice step, which keeps the arriving key
  a_budget: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv2 |=>
      (o_budget == ($past(s1_pix.spent) & BUDGET_MASK)) || (o_key == $past(s1_pix.from)))
    else $error("budget changed without crevice step");

  // Codes above refused never appear
  a_code: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> o_key <= GRANT_REFUSED)
    else $error("grant code out of range");

endmodule

`default_nettype wire

// File: tb/ckfc_flood_monitor.sv
`timescale 1ns / 1ps
// Monitor for the chroma key flood classifier: tracks register writes, predicts each
// grant from the accepted pixel items, and compares results in order. Depends on ckfc_pkg
// and the pixel, grant and cfg channel interfaces.

module ckfc_flood_monitor (
  input  logic  clk,
  input  logic  rst,
  ckfc_pixel_if pixel,
  ckfc_grant_if grant,
  ckfc_cfg_if   cfg,
  output int    mismatch_count,
  output int    grants_owed
);
  import ckfc_pkg::*;

  localparam int SLOTS = 4;

  typedef struct packed {
    logic [GRANT_W-1:0]  key;
    logic [BUDGET_W-1:0] after;
  } grant_t;

  key_t                key_slot [SLOTS];
  logic [COUNT_W-1:0]  key_count;
  logic [BUDGET_W-1:0] crevice_cap;
  logic [TOL_W-1:0]    crevice_margin;
  grant_t              pending_grants [$];

  function automatic logic [CHAN_W-1:0] step_gap(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] s;
    s = {1'b0, a} - {1'b0, b};
    return s[CHAN_W] ? CHAN_W'(-s) : s[CHAN_W-1:0];
  endfunction

  // Max-channel distance scaled to Q8.8 so it compares directly with a tolerance
  function automatic logic [TOL_W-1:0] q8_gap(input key_t k, input pixel_t p);
    logic [CHAN_W-1:0] worst;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    worst = step_gap(p.red, k.red);
    g = step_gap(p.green, k.green);
    b = step_gap(p.blue, k.blue);
    if (g > worst) worst = g;
    if (b > worst) worst = b;
    return {worst, {FRAC_W{1'b0}}};
  endfunction

  function automatic logic [GRANT_W-1:0] first_taker(input pixel_t p, input int usable);
    logic [GRANT_W-1:0] taker;
    taker = GRANT_REFUSED;
    for (int i = usable - 1; i >= 0; i--) begin
      if (!key_slot[i].island && q8_gap(key_slot[i], p) <= key_slot[i].tol)
        taker = i[GRANT_W-1:0];
    end
    return taker;
  endfunction

  function automatic grant_t classify_pixel(input pixel_t p);
    grant_t            res;
    int                usable;
    key_t              own;
    logic [TOL_W-1:0]  own_gap;
    usable = (key_count > SLOTS) ? SLOTS : int'(key_count);
    res.key = GRANT_REFUSED;
    res.after = p.spent;
    if (p.alpha == '0) begin
      res.key = GRANT_CLEAR;
    end else if (p.from == GRANT_CLEAR) begin
      res.key = first_taker(p, usable);
    end else if (int'(p.from) < usable) begin
      own = key_slot[p.from[1:0]];
      own_gap = q8_gap(own, p);
      if (own_gap <= own.tol) begin
        res.key = p.from;
      end else begin
        res.key = first_taker(p, usable);
        // weak crevice step: arriving key holds on and one budget unit is spent
        if (res.key == GRANT_REFUSED && crevice_cap != '0 && p.spent < crevice_cap &&
            {1'b0, own_gap} <= {1'b0, own.tol} + {1'b0, crevice_margin}) begin
          res.key = p.from;
          res.after = p.spent + 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_t p;
    grant_t got;
    grant_t want;
    int     bad;
    bad = 0;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) key_slot[i] = '0;
      key_count = '0;
      crevice_cap = '0;
      crevice_margin = '0;
      pending_grants.delete();
      mismatch_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_t'(cfg.index))
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_slot[cfg.index[1:0]] = cfg.data;
          REG_KEY_CNT: key_count = cfg.data[COUNT_W-1:0];
          REG_BUDGET:  crevice_cap = cfg.data[BUDGET_W-1:0];
          REG_MARGIN:  crevice_margin = cfg.data[TOL_W-1:0];
          default: ;
        endcase
      end
      if (pixel.valid && pixel.ready) begin
        p.red = pixel.pixel_red;
        p.green = pixel.pixel_green;
        p.blue = pixel.pixel_blue;
        p.alpha = pixel.pixel_alpha;
        p.from = pixel.arriving_key;
        p.spent = pixel.spent_budget;
        pending_grants = {pending_grants, classify_pixel(p)};
      end
      if (grant.valid && grant.ready) begin
        got.key = grant.granted_key;
        got.after = grant.budget_after;
        if (pending_grants.size() == 0) begin
          $display("%0t: unexpected grant item, got key %0d budget %0d",
                   $time, got.key, got.after);
          bad++;
        end else begin
          want = pending_grants.pop_front();
          if (got.key !== want.key) begin
            $display("%0t: granted_key expected %0d, got %0d", $time, want.key, got.key);
            bad++;
          end
          if (got.after !== want.after) begin
            $display("%0t: budget_after expected %0d, got %0d",
                     $time, want.after, got.after);
            bad++;
          end
        end
      end
      mismatch_count <= mismatch_count + bad;
    end
    grants_owed <= pending_grants.size();
  end

endmodule

// File: tb/tb_chroma_key_flood_classifier.sv
`timescale 1ns / 1ps
// Top of the chroma key flood classifier testbench: clock, reset, register setup,
// directed and random pixel items under varying idle patterns, and the verdict.
// Depends on ckfc_pkg, the channel interfaces, the DUT and ckfc_flood_monitor.

module tb_chroma_key_flood_classifier;
  import ckfc_pkg::*;

  localparam int IDLE_LIMIT     = 5000;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_MODE = 42;
  localparam logic [GRANT_W-1:0] NO_SUCH_KEY = 3'd7;

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   snk_stall_pct;
  int   idle_cycles;
  int   mismatch_count;
  int   grants_owed;

  // what was last written, used to aim random pixels near the keys
  key_t                stim_keys [4];
  logic [BUDGET_W-1:0] stim_budget;
  logic [TOL_W-1:0]    stim_margin;

  ckfc_pixel_if pixel_ch ();
  ckfc_grant_if grant_ch ();
  ckfc_cfg_if   cfg_ch ();

  chroma_key_flood_classifier dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_ch),
    .grant (grant_ch),
    .cfg   (cfg_ch)
  );

  ckfc_flood_monitor flood_mon (
    .clk            (clk),
    .rst            (rst),
    .pixel          (pixel_ch),
    .grant          (grant_ch),
    .cfg            (cfg_ch),
    .mismatch_count (mismatch_count),
    .grants_owed    (grants_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    grant_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (pixel_ch.valid && pixel_ch.ready) || (grant_ch.valid && grant_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic pixel_t pix(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, input logic [7:0] a,
                                 input logic [GRANT_W-1:0] from,
                                 input logic [BUDGET_W-1:0] spent);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.alpha = a;
    p.from = from;
    p.spent = spent;
    return p;
  endfunction

  function automatic key_t key_word(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic [TOL_W-1:0] tol,
                                    input logic island, input logic spare);
    key_t k;
    k.red = r;
    k.green = g;
    k.blue = b;
    k.tol = tol;
    k.island = island;
    k.spare = spare;
    return k;
  endfunction

  function automatic logic [CHAN_W-1:0] near_chan(input logic [CHAN_W-1:0] base,
                                                  input int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CHAN_W'(v);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    key_t   k;
    int     spread;
    int     sel;
    k = stim_keys[$urandom_range(0, 3)];
    spread = 1 + int'(k.tol >> FRAC_W) + int'(stim_margin >> FRAC_W);
    if (spread > 255) spread = 255;
    if ($urandom_range(0, 9) < 6) begin
      p.red = near_chan(k.red, spread);
      p.green = near_chan(k.green, spread);
      p.blue = near_chan(k.blue, spread);
    end else begin
      p.red = CHAN_W'($urandom_range(0, 255));
      p.green = CHAN_W'($urandom_range(0, 255));
      p.blue = CHAN_W'($urandom_range(0, 255));
    end
    p.alpha = ($urandom_range(0, 9) == 0) ? '0 : CHAN_W'($urandom_range(1, 255));
    sel = $urandom_range(0, 19);
    if (sel < 14) p.from = GRANT_W'($urandom_range(0, 3));
    else if (sel < 18) p.from = GRANT_CLEAR;
    else p.from = GRANT_W'($urandom_range(GRANT_REFUSED, NO_SUCH_KEY));
    if ($urandom_range(0, 1) == 0) p.spent = BUDGET_W'($urandom_range(0, 15));
    else p.spent = BUDGET_W'($urandom_range(0, stim_budget));
    return p;
  endfunction

  // leaves valid high; the caller lowers it once the write sequence is done
  task automatic write_reg(input cfg_idx_t idx, input logic [KEY_WORD_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: stim_keys[idx[1:0]] = value;
      REG_BUDGET: stim_budget = value[BUDGET_W-1:0];
      REG_MARGIN: stim_margin = value[TOL_W-1:0];
      default: ;
    endcase
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic push_pixel(input pixel_t p);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.pixel_red <= p.red;
    pixel_ch.pixel_green <= p.green;
    pixel_ch.pixel_blue <= p.blue;
    pixel_ch.pixel_alpha <= p.alpha;
    pixel_ch.arriving_key <= p.from;
    pixel_ch.spent_budget <= p.spent;
    do @(posedge clk); while (!pixel_ch.ready);
  endtask

  task automatic wait_idle();
    pixel_ch.valid <= 1'b0;
    do @(posedge clk); while (grants_owed != 0);
  endtask

  task automatic load_phase(input int phase);
    logic [TOL_W-1:0] tol;
    key_t             k;
    int               count;
    int               budget;
    int               margin;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 7))
        0, 1, 2: tol = TOL_W'($urandom_range(0, 'h0800));
        3, 4, 5: tol = TOL_W'($urandom_range(0, 'h3FFF));
        6:       tol = TOL_W'($urandom_range(0, 'hFFFF));
        default: tol = ($urandom_range(0, 1) == 0) ? '0 : '1;
      endcase
      if (phase == 2) tol = '1;
      if (phase == 3) tol = '0;
      k = key_word(CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                   CHAN_W'($urandom_range(0, 255)), tol, $urandom_range(0, 3) == 0,
                   $urandom_range(0, 1) == 1);
      write_reg(cfg_idx_t'(int'(REG_KEY0) + i), k);
    end
    case (phase)
      0: begin count = 0; budget = 15; margin = 'hFFFF; end
      1: begin count = 7; budget = 0;  margin = 0; end
      2: begin count = 4; budget = 15; margin = 'hFFFF; end
      3: begin count = 4; budget = 1;  margin = $urandom_range(0, 'h0400); end
      default: begin
        count = $urandom_range(1, 7);
        budget = $urandom_range(0, 15);
        margin = ($urandom_range(0, 7) == 0) ? 'hFFFF : $urandom_range(0, 'h1000);
      end
    endcase
    write_reg(REG_KEY_CNT, KEY_WORD_W'(count));
    write_reg(REG_BUDGET, KEY_WORD_W'(budget));
    write_reg(REG_MARGIN, KEY_WORD_W'(margin));
  endtask

  initial begin
    rst = 1'b1;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    idle_cycles = 0;
    pixel_ch.valid = 1'b0;
    pixel_ch.pixel_red = '0;
    pixel_ch.pixel_green = '0;
    pixel_ch.pixel_blue = '0;
    pixel_ch.pixel_alpha = '0;
    pixel_ch.arriving_key = '0;
    pixel_ch.spent_budget = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_KEY0;
    cfg_ch.data = '0;
    grant_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // key1 is an island; key3 needs an exact match
    write_reg(REG_KEY0, key_word(8'h10, 8'h20, 8'h30, 16'h0800, 1'b0, 1'b0));
    write_reg(REG_KEY1, key_word(8'h80, 8'h80, 8'h80, 16'h1000, 1'b1, 1'b0));
    write_reg(REG_KEY2, key_word(8'hFF, 8'hFF, 8'hFF, 16'h2000, 1'b0, 1'b0));
    write_reg(REG_KEY3, key_word(8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1));
    write_reg(REG_KEY_CNT, KEY_WORD_W'(4));
    write_reg(REG_BUDGET, KEY_WORD_W'(3));
    write_reg(REG_MARGIN, KEY_WORD_W'(16'h0400));
    cfg_ch.valid <= 1'b0;
    push_pixel(pix(8'h55, 8'h66, 8'h77, 8'h00, NO_SUCH_KEY, 4'hF));
    push_pixel(pix(8'h10, 8'h20, 8'h30, 8'h00, 3'd0, 4'h3));
    push_pixel(pix(8'h10, 8'h20, 8'h30, 8'hFF, GRANT_CLEAR, 4'h0));
    push_pixel(pix(8'h80, 8'h80, 8'h80, 8'h01, GRANT_CLEAR, 4'h7));
    push_pixel(pix(8'h82, 8'h7E, 8'h80, 8'h80, 3'd1, 4'h0));
    push_pixel(pix(8'h18, 8'h28, 8'h38, 8'hFF, 3'd0, 4'h0));
    push_pixel(pix(8'h19, 8'h20, 8'h30, 8'hFF, 3'd0, 4'h0));
    push_pixel(pix(8'h1A, 8'h20, 8'h30, 8'hFF, 3'd0, 4'h2));
    push_pixel(pix(8'h1C, 8'h20, 8'h30, 8'hFF, 3'd0, 4'h0));
    push_pixel(pix(8'h1D, 8'h20, 8'h30, 8'hFF, 3'd0, 4'h0));
    push_pixel(pix(8'h1A, 8'h20, 8'h30, 8'hFF, 3'd0, 4'h3));
    push_pixel(pix(8'h1A, 8'h20, 8'h30, 8'hFF, 3'd0, 4'hF));
    push_pixel(pix(8'h00, 8'h00, 8'h00, 8'hFF, 3'd0, 4'h5));
    push_pixel(pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, GRANT_CLEAR, 4'h0));
    push_pixel(pix(8'h00, 8'h00, 8'h00, 8'h01, GRANT_CLEAR, 4'h0));
    push_pixel(pix(8'h10, 8'h20, 8'h30, 8'hFF, GRANT_REFUSED, 4'h0));
    push_pixel(pix(8'h10, 8'h20, 8'h30, 8'hFF, NO_SUCH_KEY, 4'h1));
    push_pixel(pix(8'h10, 8'h20, 8'h30, 8'hFF, 3'd2, 4'h0));
    wait_idle();

    // tolerance plus margin past 16 bits; keys beyond the count
    write_reg(REG_KEY0, key_word(8'h00, 8'h00, 8'h00, 16'h8000, 1'b0, 1'b0));
    write_reg(REG_KEY1, key_word(8'hFF, 8'hFF, 8'hFF, 16'h0000, 1'b0, 1'b0));
    write_reg(REG_KEY_CNT, KEY_WORD_W'(2));
    write_reg(REG_BUDGET, KEY_WORD_W'(15));
    write_reg(REG_MARGIN, KEY_WORD_W'(16'hFFFF));
    cfg_ch.valid <= 1'b0;
    push_pixel(pix(8'h90, 8'h00, 8'h00, 8'hFF, 3'd0, 4'h4));
    push_pixel(pix(8'h00, 8'h00, 8'h00, 8'hFF, 3'd2, 4'h0));
    push_pixel(pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd3, 4'h0));
    wait_idle();
    write_reg(REG_BUDGET, KEY_WORD_W'(0));
    cfg_ch.valid <= 1'b0;
    push_pixel(pix(8'h90, 8'h00, 8'h00, 8'hFF, 3'd0, 4'h4));
    wait_idle();
    // count above the slot number acts as all four slots
    write_reg(REG_KEY_CNT, KEY_WORD_W'(7));
    cfg_ch.valid <= 1'b0;
    push_pixel(pix(8'h00, 8'h00, 8'h00, 8'hFF, 3'd3, 4'h0));
    push_pixel(pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, GRANT_CLEAR, 4'h0));

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      src_idle_pct = 0;
      snk_stall_pct = 0;
      load_phase(phase);
      cfg_ch.valid <= 1'b0;
      for (int mode = 0; mode < 4; mode++) begin
        case (mode)
          0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
          1: begin src_idle_pct = 83; snk_stall_pct = 0;  end
          2: begin src_idle_pct = 0;  snk_stall_pct = 83; end
          default: begin src_idle_pct = 31; snk_stall_pct = 31; end
        endcase
        repeat (ITEMS_PER_MODE) push_pixel(random_pixel());
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/ckfc_pkg.sv
sv/ckfc_pixel_if.sv
sv/ckfc_grant_if.sv
sv/ckfc_cfg_if.sv
sv/ckfc_cfg.sv
sv/ckfc_core.sv
sv/chroma_key_flood_classifier.sv
tb/ckfc_flood_monitor.sv
tb/tb_chroma_key_flood_classifier.sv
